// ===== src/cursor_list_engine_macros.svh =====
// Assertion macros for the cursor list engine.
`ifndef CURSOR_LIST_ENGINE_MACROS_SVH
`define CURSOR_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside of reset.
`define CLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CLE_ASSERT(lbl, prop, msg)
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/cle_pkg.sv =====
// Types, constants and helpers shared by the cursor list engine.
`default_nettype none

package cle_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_START  = 3'd2,
    CMD_END    = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_PREV   = 3'd5,
    CMD_POS    = 3'd6,
    CMD_READ   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOTHING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         target_position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_e                  status;
    logic [POS_W-1:0]         cursor_out;
    logic [POS_W-1:0]         length_out;
  } res_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                   shift_up;
    logic                   shift_down;
    logic [CNT_W-1:0]       cursor;
    logic [VALUE_WIDTH-1:0] value;
  } cell_ctl_t;

  // Narrow (or widen) an input value to the stored width.
  function automatic logic [VALUE_WIDTH-1:0] to_store(input logic signed [DATA_W-1:0] v);
    logic signed [VALUE_WIDTH-1:0] s;
    s = VALUE_WIDTH'(v);
    return s;
  endfunction

  // Sign-extend (or truncate) a stored value back to the result width.
  function automatic logic signed [DATA_W-1:0] from_store(input logic [VALUE_WIDTH-1:0] v);
    logic signed [VALUE_WIDTH-1:0] s;
    s = v;
    return DATA_W'(s);
  endfunction

endpackage

`default_nettype wire

// ===== src/cle_cell.sv =====
// One list entry: holds a value and, on insert or remove, takes a neighbor's value or the new one.
`default_nettype none

module cle_cell (
  input  wire logic                            clk_i,
  input  wire cle_pkg::cell_ctl_t              ctl_i,
  input  wire logic [cle_pkg::IDX_W-1:0]       idx_i,
  input  wire logic [cle_pkg::VALUE_WIDTH-1:0] left_i,
  input  wire logic [cle_pkg::VALUE_WIDTH-1:0] right_i,
  output logic      [cle_pkg::VALUE_WIDTH-1:0] data_o
);
  import cle_pkg::*;

  logic [VALUE_WIDTH-1:0] data_q, data_d;
  logic [CNT_W-1:0]       pos;

  assign pos = CNT_W'(idx_i);

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      if (pos > ctl_i.cursor) begin
        data_d = left_i;
      end else if (pos == ctl_i.cursor) begin
        data_d = ctl_i.value;
      end
    end else if (ctl_i.shift_down) begin
      if (pos >= ctl_i.cursor) begin
        data_d = right_i;
      end
    end
  end

  // Payload only: no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== src/cle_ctrl.sv =====
// Command decode, cursor and length registers, and the result register.
`default_nettype none

`include "cursor_list_engine_macros.svh"

module cle_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire cle_pkg::req_t                   req_i,
  input  wire logic [cle_pkg::VALUE_WIDTH-1:0] rd_data_i,
  output cle_pkg::cell_ctl_t                   ctl_o,
  output logic [cle_pkg::CNT_W-1:0]            cursor_o,
  output logic                                 done_o,
  output cle_pkg::res_t                        res_o
);
  import cle_pkg::*;

  logic [CNT_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  res_t             res_q, res_d;
  logic             up, dn;
  status_e          st;
  logic signed [DATA_W-1:0] val;
  logic [CNT_W-1:0] tgt;

  assign tgt = CNT_W'(req_i.target_position);

  always_comb begin
    cursor_d = cursor_q;
    count_d  = count_q;
    st       = ST_OK;
    val      = '0;
    up       = 1'b0;
    dn       = 1'b0;
    unique case (req_i.cmd) inside
      CMD_INSERT: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          up      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_REMOVE, CMD_READ: begin
        if (count_q == '0) begin
          st = ST_EMPTY;
        end else if (cursor_q >= count_q) begin
          st = ST_NOTHING;
        end else begin
          val = from_store(rd_data_i);
          if (req_i.cmd == CMD_REMOVE) begin
            dn      = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
      end
      CMD_START: cursor_d = '0;
      CMD_END:   cursor_d = (count_q == '0) ? '0 : count_q - 1'b1;
      CMD_NEXT: begin
        if (cursor_q < count_q) cursor_d = cursor_q + 1'b1;
      end
      CMD_PREV: begin
        if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
      end
      CMD_POS: begin
        if (tgt <= count_q) cursor_d = tgt;
      end
      default: ;
    endcase

    res_d.result_value = val;
    res_d.status       = st;
    res_d.cursor_out   = POS_W'(cursor_d);
    res_d.length_out   = POS_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= accept_i;
      if (accept_i) begin
        cursor_q <= cursor_d;
        count_q  <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_d;
    end
  end

  assign ctl_o.shift_up   = accept_i & up;
  assign ctl_o.shift_down = accept_i & dn;
  assign ctl_o.cursor     = cursor_q;
  assign ctl_o.value      = to_store(req_i.item_value);
  assign cursor_o         = cursor_q;
  assign done_o           = done_q;
  assign res_o            = res_q;

  `CLE_ASSERT(a_cursor_in_list, cursor_q <= count_q, "cursor beyond length")
  `CLE_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "length beyond capacity")
  `CLE_ASSERT_NEXT(a_done_follows, accept_i, done_q, "result strobe missing")
  `CLE_ASSERT_NEXT(a_no_stray_done, !accept_i, !done_q, "result without transaction")
  `CLE_ASSERT(a_err_zero, !(done_q && res_q.status != ST_OK) || res_q.result_value == '0,
              "nonzero value on error")

endmodule

`default_nettype wire

// ===== src/cursor_list_engine.sv =====
// Top level of the cursor list engine: controller plus a chain of entry cells.
//
// One command is taken per clock: a transaction is accepted on a rising edge with
// start_i high and busy_o low, and busy_o never rises, so commands may follow each
// other in every cycle. The result appears on res_o with done_o high in the cycle
// right after acceptance; the receiver cannot stall, so it must capture res_o
// whenever done_o is high. Entries sit in a row of cells; those at or beyond the
// cursor shift together in the accepting cycle.
// No clearing pass follows reset; the list simply starts empty.
`default_nettype none

module cursor_list_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire cle_pkg::req_t  cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output cle_pkg::res_t       res_o
);
  import cle_pkg::*;

  logic                   accept;
  cell_ctl_t              ctl;
  logic [CNT_W-1:0]       cursor;
  logic [VALUE_WIDTH-1:0] cell_data [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Only read when cursor < length, so the wrapped index at the end is never used.
  assign rd_data = cell_data[cursor[IDX_W-1:0]];

  cle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (cmd_i),
    .rd_data_i (rd_data),
    .ctl_o     (ctl),
    .cursor_o  (cursor),
    .done_o    (done_o),
    .res_o     (res_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = ctl.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    cle_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (IDX_W'(i)),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

endmodule

`default_nettype wire
